// ===== rtl/crc16_pkg.sv =====
// Package for the CRC-16 byte engine: seed and polynomial constants and the
// byte-wide fold function. No dependencies.
package crc16_pkg;

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] CRC_SEED_RESET = 16'hC78C;

  // Fold one byte into the CRC, MSB first, eight shift steps of the poly.
  function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

// ===== rtl/crc16_ccitt_byte_engine.sv =====
// Top level of the CRC-16 (poly 0x1021, MSB first) byte engine.
// Depends on crc16_pkg for constants and the byte fold function.

// One message byte is taken per cycle while in_ready is high: the byte-wide
// fold sits between the running CRC register and the result register. A byte
// flagged first_byte restarts from the init_value seed (reset 0xC78C, written
// through cfg_wr_en/cfg_wr_data; the user must write it only while idle, as
// the block does not enforce it). A last byte's CRC enters the result register,
// or the skid register while a result waits; this two-word output stage keeps
// input flowing while a result waits. Input stalls only when both hold words.
module crc16_ccitt_byte_engine (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  // CRC result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] crc_value
);

  logic [15:0] init_value;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic        skid_valid;
  logic [15:0] skid_crc;
  logic        in_fire;
  logic        push;
  logic        pop;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && last_byte;
  assign pop      = out_valid && out_ready;

  // Reload seed on the first byte, then fold the byte in
  assign running_crc_next = crc16_pkg::crc_fold_byte(
      first_byte ? init_value : running_crc, data_byte);

  // Hold the seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      init_value <= crc16_pkg::CRC_SEED_RESET;
    end else if (cfg_wr_en) begin
      init_value <= cfg_wr_data;
    end
  end

  // Advance the running CRC on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= crc16_pkg::CRC_SEED_RESET;
    end else if (in_fire) begin
      running_crc <= running_crc_next;
    end
  end

  // Output word and skid word control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output word and skid word payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        crc_value <= skid_crc;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_crc <= running_crc_next;
      end else begin
        crc_value <= running_crc_next;
      end
    end
  end

endmodule

// ===== rtl/crc16_checker.sv =====
// Port-level checker for the CRC-16 byte engine, bound to the top level.
// Depends on crc16_pkg for the byte fold function.
module crc16_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [15:0] cfg_wr_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        first_byte,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] crc_value
);

  logic [15:0] seed_shadow;

  // Track the seed as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_shadow <= crc16_pkg::CRC_SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_shadow <= cfg_wr_data;
    end
  end

  // A stalled result word stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(crc_value))
    else $error("result word changed while stalled");

  // Input stalls only while results are waiting
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // A new result follows an accepted last byte
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_byte))
    else $error("result word without a last byte");

  // A single-byte message into an empty output gives the seed folded once
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && first_byte && last_byte && !out_valid |=>
      out_valid && crc_value ==
        crc16_pkg::crc_fold_byte($past(seed_shadow), $past(data_byte)))
    else $error("single-byte CRC mismatch");

endmodule

bind crc16_ccitt_byte_engine crc16_checker u_crc16_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .data_byte   (data_byte),
  .first_byte  (first_byte),
  .last_byte   (last_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .crc_value   (crc_value)
);
